@@ rtl/dbwc_pkg.sv @@
package dbwc_pkg;

  // Event kinds carried in the mode field.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_ACK   = 2'd1;
  localparam logic [1:0] MODE_NACK  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SEGMENT_BYTES    = 3'd0;
  localparam logic [2:0] REG_ADDITIVE_INC     = 3'd1;
  localparam logic [2:0] REG_MAX_DECREASE     = 3'd2;
  localparam logic [2:0] REG_BASE_TARGET      = 3'd3;
  localparam logic [2:0] REG_MAX_WINDOW_SEGS  = 3'd4;
  localparam logic [2:0] REG_INIT_WINDOW_SEGS = 3'd5;
  localparam logic [2:0] REG_LOSS_RESET       = 3'd6;

  // Shared divide / square root unit.
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 52;
  localparam int SQRT_IN_W  = 48;
  localparam int SQRT_OUT_W = 24;
  localparam int ITER_W     = 7;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [39:0] now_us;
    logic [39:0] echo_ts_us;
  } event_t;

  typedef struct packed {
    logic [25:0] window_bytes;
    logic [25:0] inflight_bytes;
    logic [12:0] send_count;
    logic [47:0] first_send_seq;
    logic [20:0] target_delay_out_us;
    logic        window_cut;
  } result_t;

endpackage

@@ rtl/dbwc_arith.sv @@
module dbwc_arith import dbwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  arith_req_t            req,
  input  logic [DIVIDEND_W-1:0] a,
  input  logic [DIVISOR_W-1:0]  b,
  output arith_rsp_t            rsp,
  output logic [DIVIDEND_W-1:0] result
);

  localparam logic [ITER_W-1:0] DIV_STEPS  = ITER_W'(DIVIDEND_W);
  localparam logic [ITER_W-1:0] SQRT_STEPS = ITER_W'(SQRT_IN_W / 2);

  logic                  busy;
  logic                  done;
  arith_op_t             op_r;
  logic [ITER_W-1:0]     cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  dvs;
  logic [SQRT_IN_W-1:0]  sv;
  logic [SQRT_IN_W-1:0]  sr;
  logic [SQRT_IN_W-1:0]  sbit;

  logic [DIVISOR_W:0]    r2;
  logic [DIVISOR_W:0]    rdiff;
  logic                  take;
  logic [SQRT_IN_W:0]    trial;
  logic                  sq_take;

  // Restoring division brings in one quotient bit per cycle; the square root
  // settles one root bit per cycle.
  assign r2      = {rem, quo[DIVIDEND_W-1]};
  assign rdiff   = r2 - {1'b0, dvs};
  assign take    = r2 >= {1'b0, dvs};
  assign trial   = {1'b0, sr} + {1'b0, sbit};
  assign sq_take = {1'b0, sv} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op_r <= req.op;
        if (req.op == OP_DIV) begin
          cnt <= DIV_STEPS;
          rem <= '0;
          quo <= a;
          dvs <= b;
        end else begin
          cnt  <= SQRT_STEPS;
          sv   <= a[SQRT_IN_W-1:0];
          sr   <= '0;
          sbit <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
        end
      end else if (busy) begin
        if (op_r == OP_DIV) begin
          rem <= take ? rdiff[DIVISOR_W-1:0] : r2[DIVISOR_W-1:0];
          quo <= {quo[DIVIDEND_W-2:0], take};
        end else begin
          if (sq_take) begin
            sv <= sv - trial[SQRT_IN_W-1:0];
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
        end
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = (op_r == OP_DIV) ? quo : DIVIDEND_W'(sr[SQRT_OUT_W-1:0]);

endmodule

@@ rtl/delay_based_window_control_unit.sv @@
// Channel   Dir  Signals                                   Transfer
// event     in   event_valid, event_ready, event_data      valid & ready at clk rise
// result    out  result_valid, result_ready, result_data   valid & ready at clk rise
// config    in   psel, penable, pwrite, paddr, pwdata      psel & penable & pwrite
//
// One event at a time. Acks and nacks use the shared divide / square root unit for their
// square roots and 64-bit divisions.
// Reset is synchronous and restores the register defaults and clears the flow.
// A new event is taken while a finished result still waits to be transferred;
// the next result waits for that transfer before it is loaded.
module delay_based_window_control_unit import dbwc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int TIME_BITS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        event_valid,
  output logic        event_ready,
  input  event_t      event_data,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW_W = DIVISOR_W;

  typedef enum logic [24:0] {
    ST_IDLE   = 25'h0000001,
    ST_INIT   = 25'h0000002,
    ST_MAXW   = 25'h0000004,
    ST_SQ_MIN = 25'h0000008,
    ST_SQ_MAX = 25'h0000010,
    ST_SQ_WIN = 25'h0000020,
    ST_P2000  = 25'h0000040,
    ST_RANGE  = 25'h0000080,
    ST_BRANCH = 25'h0000100,
    ST_RS     = 25'h0000200,
    ST_NUM    = 25'h0000400,
    ST_DEN    = 25'h0000800,
    ST_EXTRA  = 25'h0001000,
    ST_TGT    = 25'h0002000,
    ST_INC    = 25'h0004000,
    ST_D1000  = 25'h0008000,
    ST_SLOPE  = 25'h0010000,
    ST_RATIO  = 25'h0020000,
    ST_CUTM   = 25'h0040000,
    ST_MULCUT = 25'h0080000,
    ST_CLAMP  = 25'h0100000,
    ST_SEND   = 25'h0200000,
    ST_CNT    = 25'h0400000,
    ST_ADV    = 25'h0800000,
    ST_OUT    = 25'h1000000
  } state_t;

  // Configuration registers.
  logic [13:0] seg;
  logic [15:0] ai;
  logic [15:0] maxdec;
  logic [19:0] base;
  logic [12:0] maxseg;
  logic [12:0] initseg;
  logic [7:0]  lrc;

  // Flow state.
  logic [47:0]          window;
  logic [31:0]          inflight;
  logic [47:0]          hs;
  logic [7:0]           loss_run;
  logic [TIME_BITS-1:0] last_cut;
  logic [20:0]          target;
  logic                 started;

  // Per-event working registers.
  state_t               state;
  logic                 launched;
  logic [1:0]           mode_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] rtt_r;
  logic                 can_dec_r;
  logic [CW_W-1:0]      cw;
  logic [26:0]          maxw;
  logic [14:0]          s_min;
  logic [21:0]          s_max;
  logic [23:0]          s_win;
  logic [11:0]          range;
  logic                 valid;
  logic [26:0]          rs;
  logic [11:0]          extra;
  logic [63:0]          acc;
  logic [CW_W-1:0]      dvr;
  logic [42:0]          slope;
  logic [15:0]          ratio;
  logic [15:0]          cut;
  logic [12:0]          count;
  logic [47:0]          first;
  logic [47:0]          win_prev;

  logic [47:0]           mul_a;
  logic [23:0]           mul_b;
  logic [71:0]           mul_p;
  arith_req_t            arith_req;
  arith_rsp_t            arith_rsp;
  logic [DIVIDEND_W-1:0] arith_a;
  logic [DIVISOR_W-1:0]  arith_b;
  logic [DIVIDEND_W-1:0] arith_q;
  logic                  arith_state;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] echo_t;
  logic [TIME_BITS-1:0] rtt_in;
  logic [47:0]          win_int;
  logic [31:0]          cint;
  logic [20:0]          tgt_now;
  logic [21:0]          tgt2_now;
  logic [21:0]          tgt2;
  logic [CW_W-1:0]      maxq;
  logic [CW_W-1:0]      minq;
  logic [CW_W-1:0]      cw_hi;
  logic [63:0]          need;
  logic [63:0]          unit;
  logic [63:0]          window64;
  logic [7:0]           loss_new;
  logic [42:0]          cut_raw;
  logic [32:0]          infl_sum;
  logic [47:0]          win_out;
  logic                 cfg_write;

  assign now_t    = TIME_BITS'(event_data.now_us);
  assign echo_t   = TIME_BITS'(event_data.echo_ts_us);
  assign rtt_in   = now_t - echo_t;
  assign win_int  = window >> FRAC_BITS;
  assign cint     = (win_int > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : win_int[31:0];
  assign tgt_now  = 21'(base) + 21'(extra);
  assign tgt2_now = {tgt_now, 1'b0};
  assign tgt2     = {target, 1'b0};
  assign maxq     = CW_W'(maxw) << FRAC_BITS;
  assign minq     = CW_W'(seg) << FRAC_BITS;
  assign cw_hi    = (cw > maxq) ? maxq : cw;
  assign need     = 64'(33'(inflight) + 33'(seg)) << FRAC_BITS;
  assign unit     = 64'(seg) << FRAC_BITS;
  assign window64 = 64'(window);
  assign loss_new = (loss_run == 8'hFF) ? 8'hFF : loss_run + 8'd1;
  assign cut_raw  = mul_p[58:16];
  assign infl_sum = 33'(inflight) + 33'(mul_p[26:0]);

  // Shared multiplier; every product lands in a register.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_INIT: begin
        mul_a = 48'(initseg);
        mul_b = 24'(seg);
      end
      ST_MAXW: begin
        mul_a = 48'(maxseg);
        mul_b = 24'(seg);
      end
      ST_P2000: begin
        mul_a = window;
        mul_b = 24'd2000;
      end
      ST_RS: begin
        mul_a = 48'(range);
        mul_b = 24'(s_min);
      end
      ST_NUM: begin
        mul_a = 48'(rs);
        mul_b = 24'(s_max - 22'(s_win));
      end
      ST_DEN: begin
        mul_a = 48'(s_win);
        mul_b = 24'(s_max - 22'(s_min));
      end
      ST_D1000: begin
        mul_a = 48'(s_max - 22'(s_min));
        mul_b = 24'd1000;
      end
      ST_CUTM: begin
        mul_a = 48'(slope);
        mul_b = 24'(ratio);
      end
      ST_MULCUT: begin
        mul_a = cw[47:0];
        mul_b = 24'(17'h10000 - 17'(cut));
      end
      ST_ADV: begin
        mul_a = 48'(count);
        mul_b = 24'(seg);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 72'(mul_a) * 72'(mul_b);

  // Operands for the divide / square root unit.
  always_comb begin
    arith_a = '0;
    arith_b = '0;
    case (state)
      ST_SQ_MIN: arith_a = 64'(seg) << 16;
      ST_SQ_MAX: arith_a = 64'(maxw) << 16;
      ST_SQ_WIN: arith_a = 64'(cint) << 16;
      ST_RANGE: begin
        arith_a = acc;
        arith_b = maxq;
      end
      ST_EXTRA: begin
        arith_a = acc;
        arith_b = dvr;
      end
      ST_INC: begin
        arith_a = 64'(ai) << (2 * FRAC_BITS);
        arith_b = cw;
      end
      ST_SLOPE: begin
        arith_a = 64'(rs) << 16;
        arith_b = dvr;
      end
      ST_RATIO: begin
        arith_a = 64'(rtt_r - TIME_BITS'(tgt2)) << 16;
        arith_b = DIVISOR_W'(rtt_r);
      end
      ST_CNT: begin
        arith_a = window64 - need + unit - 64'd1;
        arith_b = DIVISOR_W'(unit);
      end
      default: begin
        arith_a = '0;
        arith_b = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_SQ_MIN, ST_SQ_MAX, ST_SQ_WIN, ST_RANGE, ST_EXTRA, ST_INC, ST_SLOPE,
      ST_RATIO, ST_CNT: arith_state = 1'b1;
      default:          arith_state = 1'b0;
    endcase
  end

  assign arith_req.start = arith_state && !launched;
  assign arith_req.op    = (state == ST_SQ_MIN || state == ST_SQ_MAX ||
                            state == ST_SQ_WIN) ? OP_SQRT : OP_DIV;

  dbwc_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (arith_req),
    .a      (arith_a),
    .b      (arith_b),
    .rsp    (arith_rsp),
    .result (arith_q)
  );

  assign event_ready = (state == ST_IDLE);
  assign win_out     = window >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launched     <= 1'b0;
      result_valid <= 1'b0;
      window       <= '0;
      inflight     <= '0;
      hs           <= '0;
      loss_run     <= '0;
      last_cut     <= '0;
      target       <= '0;
      started      <= 1'b0;
    end else begin
      if (arith_req.start) begin
        launched <= 1'b1;
      end else if (arith_rsp.done) begin
        launched <= 1'b0;
      end
      // In ST_OUT the load below decides result_valid on its own.
      if (result_valid && result_ready && state != ST_OUT) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (event_valid) begin
            mode_r    <= event_data.mode;
            now_r     <= now_t;
            rtt_r     <= rtt_in;
            can_dec_r <= (now_t - last_cut) >= rtt_in;
            count     <= '0;
            first     <= '0;
            win_prev  <= window;
            cw        <= CW_W'(window);
            if (event_data.mode == MODE_START) begin
              state <= ST_INIT;
            end else if ((event_data.mode == MODE_ACK || event_data.mode == MODE_NACK) &&
                         started) begin
              state <= ST_MAXW;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_INIT: begin
          window  <= mul_p[47:0] << FRAC_BITS;
          started <= 1'b1;
          hs      <= '0;
          state   <= ST_SEND;
        end
        ST_MAXW: begin
          maxw     <= mul_p[26:0];
          inflight <= (inflight >= 32'(seg)) ? inflight - 32'(seg) : '0;
          state    <= ST_SQ_MIN;
        end
        ST_SQ_MIN: begin
          if (arith_rsp.done) begin
            s_min <= arith_q[14:0];
            state <= ST_SQ_MAX;
          end
        end
        ST_SQ_MAX: begin
          if (arith_rsp.done) begin
            s_max <= arith_q[21:0];
            state <= ST_SQ_WIN;
          end
        end
        ST_SQ_WIN: begin
          if (arith_rsp.done) begin
            s_win <= arith_q[23:0];
            state <= ST_P2000;
          end
        end
        ST_P2000: begin
          acc   <= mul_p[63:0];
          valid <= 1'b0;
          state <= (maxw == '0) ? ST_BRANCH : ST_RANGE;
        end
        ST_RANGE: begin
          if (arith_rsp.done) begin
            valid <= (arith_q < 64'd4000) && (22'(s_min) < s_max);
            range <= 12'd4000 - arith_q[11:0];
            state <= ST_BRANCH;
          end
        end
        ST_BRANCH: begin
          if (mode_r == MODE_NACK) begin
            loss_run <= loss_new;
            if (loss_new >= lrc) begin
              cw    <= minq;
              state <= ST_CLAMP;
            end else if (can_dec_r) begin
              cut   <= maxdec;
              state <= ST_MULCUT;
            end else begin
              state <= ST_CLAMP;
            end
          end else begin
            loss_run <= '0;
            state    <= ST_RS;
          end
        end
        ST_RS: begin
          rs    <= mul_p[26:0];
          extra <= '0;
          if (valid && s_win != '0 && s_max >= 22'(s_win)) begin
            state <= ST_NUM;
          end else begin
            state <= ST_TGT;
          end
        end
        ST_NUM: begin
          acc   <= mul_p[63:0];
          state <= ST_DEN;
        end
        ST_DEN: begin
          dvr   <= mul_p[CW_W-1:0];
          state <= ST_EXTRA;
        end
        ST_EXTRA: begin
          if (arith_rsp.done) begin
            extra <= (arith_q > 64'(range)) ? range : arith_q[11:0];
            state <= ST_TGT;
          end
        end
        ST_TGT: begin
          target <= tgt_now;
          if (rtt_r < TIME_BITS'(tgt2_now)) begin
            if (cw >= (CW_W'(1) << FRAC_BITS)) begin
              state <= ST_INC;
            end else begin
              cw    <= cw + (CW_W'(ai) << FRAC_BITS);
              state <= ST_CLAMP;
            end
          end else if (can_dec_r) begin
            last_cut <= now_r;
            slope    <= '0;
            ratio    <= '0;
            if (valid) begin
              state <= ST_D1000;
            end else if (rtt_r != '0) begin
              state <= ST_RATIO;
            end else begin
              state <= ST_CUTM;
            end
          end else begin
            state <= ST_CLAMP;
          end
        end
        ST_INC: begin
          if (arith_rsp.done) begin
            cw    <= cw + arith_q[CW_W-1:0];
            state <= ST_CLAMP;
          end
        end
        ST_D1000: begin
          dvr   <= mul_p[CW_W-1:0];
          state <= ST_SLOPE;
        end
        ST_SLOPE: begin
          if (arith_rsp.done) begin
            slope <= arith_q[42:0];
            state <= (rtt_r != '0) ? ST_RATIO : ST_CUTM;
          end
        end
        ST_RATIO: begin
          if (arith_rsp.done) begin
            ratio <= arith_q[15:0];
            state <= ST_CUTM;
          end
        end
        ST_CUTM: begin
          cut   <= (cut_raw > 43'(maxdec)) ? maxdec : cut_raw[15:0];
          state <= ST_MULCUT;
        end
        ST_MULCUT: begin
          cw    <= CW_W'(mul_p[64:16]);
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          // The minimum wins when the limits cross.
          window <= (cw_hi < minq) ? minq[47:0] : cw_hi[47:0];
          state  <= ST_SEND;
        end
        ST_SEND: begin
          if (seg != '0 && need < window64) begin
            state <= ST_CNT;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_CNT: begin
          if (arith_rsp.done) begin
            count <= (arith_q > 64'd4096) ? 13'd4096 : arith_q[12:0];
            state <= ST_ADV;
          end
        end
        ST_ADV: begin
          first    <= hs + 48'd1;
          hs       <= hs + 48'(mul_p[26:0]);
          inflight <= infl_sum[32] ? 32'hFFFF_FFFF : infl_sum[31:0];
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid                    <= 1'b1;
            result_data.window_bytes        <= (win_out > 48'h3FF_FFFF) ? 26'h3FF_FFFF
                                                                          : win_out[25:0];
            result_data.inflight_bytes      <= (inflight > 32'h3FF_FFFF) ? 26'h3FF_FFFF
                                                                           : inflight[25:0];
            result_data.send_count          <= count;
            result_data.first_send_seq      <= first;
            result_data.target_delay_out_us <= target;
            result_data.window_cut          <= (mode_r != MODE_START) && (window < win_prev);
            state                           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg     <= 14'd1500;
      ai      <= 16'd120;
      maxdec  <= 16'd328;
      base    <= 20'd4000;
      maxseg  <= 13'd1000;
      initseg <= 13'd27;
      lrc     <= 8'd3;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_SEGMENT_BYTES:    seg     <= pwdata[13:0];
        REG_ADDITIVE_INC:     ai      <= pwdata[15:0];
        REG_MAX_DECREASE:     maxdec  <= pwdata[15:0];
        REG_BASE_TARGET:      base    <= pwdata[19:0];
        REG_MAX_WINDOW_SEGS:  maxseg  <= pwdata[12:0];
        REG_INIT_WINDOW_SEGS: initseg <= pwdata[12:0];
        REG_LOSS_RESET:       lrc     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SEGMENT_BYTES:    prdata = 32'(seg);
      REG_ADDITIVE_INC:     prdata = 32'(ai);
      REG_MAX_DECREASE:     prdata = 32'(maxdec);
      REG_BASE_TARGET:      prdata = 32'(base);
      REG_MAX_WINDOW_SEGS:  prdata = 32'(maxseg);
      REG_INIT_WINDOW_SEGS: prdata = 32'(initseg);
      REG_LOSS_RESET:       prdata = 32'(lrc);
      default:              prdata = '0;
    endcase
  end

  // The shared unit is only started when it has finished the previous job.
  a_arith_idle_start: assert property (@(posedge clk) disable iff (rst)
    arith_req.start |-> !arith_rsp.busy)
    else $error("arith unit started while busy");

  // In the cycle after an event transfer, event_ready is low.
  a_event_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_ready |=> !event_ready)
    else $error("event taken while one is in progress");

  a_burst_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.send_count <= 13'd4096)
    else $error("send burst over limit");

  a_no_seq_without_send: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.send_count == 13'd0 |-> result_data.first_send_seq == 48'd0)
    else $error("sequence reported with nothing to send");

endmodule

@@ tb/tb_delay_based_window_control_unit.sv @@
`timescale 1ns / 100ps

module tb_delay_based_window_control_unit;
  import dbwc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [63:0] TMASK = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] M26 = 64'h3FF_FFFF;
  localparam logic [39:0] TMAX = 40'hFF_FFFF_FFFF;
  localparam int N_DIR = 19;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 165;

  typedef struct packed {
    logic [1:0]  mode;
    logic [39:0] now_us;
    logic [39:0] echo_ts_us;
    logic        fixed;
    result_t     res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        event_valid = 1'b0;
  logic        event_ready;
  event_t      event_data = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Register copy and flow state of the window predictor.
  logic [63:0] cfg_seg, cfg_ai, cfg_md, cfg_base, cfg_maxseg, cfg_init, cfg_loss;
  logic [63:0] win_q, infl, hi_seq, loss_cnt, last_cut, tgt_us;
  bit          started;

  result_t expected_q[$];
  bit      idle_on = 1'b1;
  int      mismatches = 0;
  int      events_sent = 0;
  int      results_seen = 0;
  int      cuts_seen = 0;

  dir_row_t dir_tab [0:N_DIR-1] = '{
    '{MODE_ACK, 40'd1000, 40'd500, 1'b1, '0},
    '{MODE_NACK, 40'd2000, 40'd1000, 1'b1, '0},
    '{MODE_UNUSED, 40'd3000, 40'd0, 1'b1, '0},
    '{MODE_START, 40'd0, 40'd0, 1'b1,
      result_t'{26'd40500, 26'd39000, 13'd26, 48'd1, 21'd0, 1'b0}},
    '{MODE_ACK, 40'd10000, 40'd9000, 1'b0, '0},
    '{MODE_ACK, 40'd60000, 40'd10000, 1'b0, '0},
    '{MODE_ACK, 40'd60000, 40'd60000, 1'b0, '0},
    '{MODE_ACK, 40'd200000, 40'd0, 1'b0, '0},
    '{MODE_NACK, 40'd210000, 40'd200000, 1'b0, '0},
    '{MODE_NACK, 40'd220000, 40'd210000, 1'b0, '0},
    '{MODE_NACK, 40'd230000, 40'd220000, 1'b0, '0},
    '{MODE_NACK, 40'd240000, 40'd230000, 1'b0, '0},
    '{MODE_ACK, 40'd250000, 40'd249000, 1'b0, '0},
    '{MODE_ACK, 40'd0, TMAX, 1'b0, '0},
    '{MODE_ACK, TMAX, 40'd0, 1'b0, '0},
    '{MODE_UNUSED, TMAX, TMAX, 1'b0, '0},
    '{MODE_START, TMAX, TMAX, 1'b0, '0},
    '{MODE_ACK, TMAX, TMAX - 40'd100, 1'b0, '0},
    '{MODE_NACK, TMAX, 40'd0, 1'b0, '0}
  };

  delay_based_window_control_unit u_top (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_ready(event_ready), .event_data(event_data),
    .result_valid(result_valid), .result_ready(result_ready), .result_data(result_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat26(input logic [63:0] v);
    return (v > M26) ? M26 : v;
  endfunction

  task automatic predict_window(input event_t ev, output result_t res);
    logic [63:0] now, echo, seg, minw, maxw, win_prev, cnt, first, cw, rtt;
    logic [63:0] smin, smax, swin, cint, tgt, slope, ratio, cut, need, unit;
    longint rng, extra, num, den;
    bit ok, can_dec, act;
    now = {24'd0, ev.now_us};
    echo = {24'd0, ev.echo_ts_us};
    seg = cfg_seg;
    minw = seg;
    maxw = cfg_maxseg * seg;
    win_prev = win_q;
    cnt = 0;
    first = 0;
    act = 1'b0;
    if (ev.mode == MODE_START) begin
      started = 1'b1;
      hi_seq = 0;
      win_q = ((cfg_init * seg) << 16) & M48;
      win_prev = win_q;
      act = 1'b1;
    end else if ((ev.mode == MODE_ACK || ev.mode == MODE_NACK) && started) begin
      cw = win_q;
      rtt = (now - echo) & TMASK;
      can_dec = ((now - last_cut) & TMASK) >= rtt;
      rng = 0;
      smin = int_sqrt(minw << 16);
      smax = int_sqrt(maxw << 16);
      cint = cw >> 16;
      if (cint > M32) cint = M32;
      swin = int_sqrt(cint << 16);
      if (maxw != 0) rng = 4000 - longint'((64'd2000 * cw) / (maxw << 16));
      ok = (maxw != 0) && (rng > 0) && (smax > smin);
      infl = (infl >= seg) ? infl - seg : 64'd0;
      if (ev.mode == MODE_ACK) begin
        loss_cnt = 0;
        extra = 0;
        if (ok && swin != 0) begin
          num = rng * longint'(smin) * (longint'(smax) - longint'(swin));
          den = longint'(swin) * longint'(smax - smin);
          extra = num / den;
          if (extra > rng) extra = rng;
          if (extra < 0) extra = 0;
        end
        tgt = cfg_base + 64'(extra);
        if (tgt > 64'h1F_FFFF) tgt = 64'h1F_FFFF;
        tgt_us = tgt;
        if (rtt < 2 * tgt) begin
          if (cw >= 64'h1_0000) cw = cw + (((cfg_ai << 16) << 16) / cw);
          else cw = cw + (cfg_ai << 16);
        end else if (can_dec) begin
          slope = 0;
          ratio = 0;
          if (ok) slope = ((64'(rng) * smin) << 16) / (64'd1000 * (smax - smin));
          if (rtt != 0) ratio = ((rtt - 2 * tgt) << 16) / rtt;
          cut = (slope * ratio) >> 16;
          if (cut > cfg_md) cut = cfg_md;
          cw = (cw * (64'd65536 - cut)) >> 16;
          last_cut = now;
        end
      end else begin
        if (loss_cnt < 255) loss_cnt = loss_cnt + 1;
        if (loss_cnt >= cfg_loss) cw = minw << 16;
        else if (can_dec) cw = (cw * (64'd65536 - cfg_md)) >> 16;
      end
      if (cw > (maxw << 16)) cw = maxw << 16;
      if (cw < (minw << 16)) cw = minw << 16;
      win_q = cw & M48;
      act = 1'b1;
    end
    if (act && seg != 0) begin
      need = (infl + seg) << 16;
      unit = seg << 16;
      if (need < win_q) begin
        cnt = (win_q - need + unit - 1) / unit;
        if (cnt > 4096) cnt = 4096;
      end
      if (cnt != 0) begin
        first = (hi_seq + 1) & M48;
        hi_seq = (hi_seq + cnt * seg) & M48;
        infl = infl + cnt * seg;
        if (infl > M32) infl = M32;
      end
    end
    res.window_bytes = sat26(win_q >> 16);
    res.inflight_bytes = sat26(infl);
    res.send_count = cnt[12:0];
    res.first_send_seq = first[47:0];
    res.target_delay_out_us = tgt_us[20:0];
    res.window_cut = (ev.mode != MODE_START) && (win_q < win_prev);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_event(input event_t ev, input bit fixed, input result_t fixed_res);
    result_t res;
    while (idle_on && $urandom_range(99) < 23) begin
      event_valid <= 1'b0;
      @(negedge clk);
    end
    event_valid <= 1'b1;
    event_data <= ev;
    do @(posedge clk); while (!event_ready);
    predict_window(ev, res);
    expected_q.push_back(fixed ? fixed_res : res);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SEGMENT_BYTES:    cfg_seg = val & 32'h3FFF;
      REG_ADDITIVE_INC:     cfg_ai = val & 32'hFFFF;
      REG_MAX_DECREASE:     cfg_md = val & 32'hFFFF;
      REG_BASE_TARGET:      cfg_base = val & 32'hF_FFFF;
      REG_MAX_WINDOW_SEGS:  cfg_maxseg = val & 32'h1FFF;
      REG_INIT_WINDOW_SEGS: cfg_init = val & 32'h1FFF;
      REG_LOSS_RESET:       cfg_loss = val & 32'hFF;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    result_ready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
  end

  always @(posedge clk) begin
    result_t exp;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", result_data);
      end else begin
        exp = expected_q.pop_front();
        if (result_data.window_cut) cuts_seen++;
        if (result_data.window_bytes !== exp.window_bytes ||
            result_data.inflight_bytes !== exp.inflight_bytes ||
            result_data.send_count !== exp.send_count ||
            result_data.first_send_seq !== exp.first_send_seq ||
            result_data.target_delay_out_us !== exp.target_delay_out_us ||
            result_data.window_cut !== exp.window_cut) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %p, got %p",
                     results_seen, exp, result_data);
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    event_t ev;
    logic [39:0] t_now, rtt;
    logic [63:0] span;
    int sel;
    cfg_seg = 1500; cfg_ai = 120; cfg_md = 328; cfg_base = 4000;
    cfg_maxseg = 1000; cfg_init = 27; cfg_loss = 3;
    win_q = 0; infl = 0; hi_seq = 0; loss_cnt = 0; last_cut = 0; tgt_us = 0;
    started = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      ev.mode = dir_tab[i].mode;
      ev.now_us = dir_tab[i].now_us;
      ev.echo_ts_us = dir_tab[i].echo_ts_us;
      send_event(ev, dir_tab[i].fixed, dir_tab[i].res);
    end
    event_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      while (expected_q.size() != 0) @(negedge clk);
      idle_on = (ph != 2);
      case (ph)
        0: begin
          write_reg(REG_SEGMENT_BYTES, 1500); write_reg(REG_ADDITIVE_INC, 120);
          write_reg(REG_MAX_DECREASE, 328); write_reg(REG_BASE_TARGET, 4000);
          write_reg(REG_MAX_WINDOW_SEGS, 1000); write_reg(REG_INIT_WINDOW_SEGS, 27);
          write_reg(REG_LOSS_RESET, 3);
        end
        1: begin
          write_reg(REG_SEGMENT_BYTES, 64); write_reg(REG_ADDITIVE_INC, 65535);
          write_reg(REG_MAX_DECREASE, 65535); write_reg(REG_BASE_TARGET, 0);
          write_reg(REG_MAX_WINDOW_SEGS, 1); write_reg(REG_INIT_WINDOW_SEGS, 1);
          write_reg(REG_LOSS_RESET, 1);
        end
        2: begin
          write_reg(REG_SEGMENT_BYTES, 9000); write_reg(REG_ADDITIVE_INC, 0);
          write_reg(REG_MAX_DECREASE, 0); write_reg(REG_BASE_TARGET, 1000000);
          write_reg(REG_MAX_WINDOW_SEGS, 4096); write_reg(REG_INIT_WINDOW_SEGS, 4096);
          write_reg(REG_LOSS_RESET, 255);
        end
        default: begin
          write_reg(REG_SEGMENT_BYTES, $urandom_range(9000, 64));
          write_reg(REG_ADDITIVE_INC, $urandom_range(65535));
          write_reg(REG_MAX_DECREASE, $urandom_range(20000));
          write_reg(REG_BASE_TARGET, $urandom_range(50000));
          write_reg(REG_MAX_WINDOW_SEGS, $urandom_range(4096, 1));
          write_reg(REG_INIT_WINDOW_SEGS, $urandom_range(200, 1));
          write_reg(REG_LOSS_RESET, $urandom_range(6, 1));
        end
      endcase

      // Odd phases run the clock up to the wrap point of the time field.
      t_now = (ph % 2) ? TMAX - 40'd2000000 : 40'($urandom_range(100000));
      span = 3 * (cfg_base + 4000) + 1000;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        sel = $urandom_range(99);
        t_now = t_now + 40'($urandom_range(50000, 1));
        if (k == 0 || sel < 3) begin
          ev.mode = MODE_START;
        end else if (sel < 85) begin
          ev.mode = (sel < 65) ? MODE_ACK : MODE_NACK;
        end else begin
          ev.mode = 2'($urandom_range(3));
        end
        if (sel < 85) begin
          rtt = 40'($urandom_range(32'(span)));
          ev.now_us = t_now;
          ev.echo_ts_us = t_now - rtt;
        end else begin
          ev.now_us = 40'({$urandom, $urandom});
          ev.echo_ts_us = 40'({$urandom, $urandom});
        end
        send_event(ev, 1'b0, '0);
      end
      event_valid <= 1'b0;
    end

    idle_on = 1'b1;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    $display("Sent %0d events over %0d register settings; %0d results checked, %0d window cuts.",
             events_sent, PHASES, results_seen, cuts_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
